@@ rtl/core/rv32ex_pkg.sv @@
`default_nettype none

package rv32ex_pkg;

    localparam int PC_WIDTH        = 16;
    localparam int CODE_ADDR_WIDTH = 16;
    localparam int XLEN            = 32;
    localparam int IMM_WIDTH       = 20;
    localparam int SHAMT_WIDTH     = 5;
    localparam int UPPER_SHIFT     = 12;
    localparam int INSTR_BYTES     = 4;

    typedef enum logic [2:0] {
        TYPE_R = 3'd0,
        TYPE_I = 3'd1,
        TYPE_S = 3'd2,
        TYPE_B = 3'd3,
        TYPE_U = 3'd4,
        TYPE_J = 3'd5
    } t_instr_type;

    localparam logic [2:0] F3_ADD  = 3'd0;
    localparam logic [2:0] F3_SLL  = 3'd1;
    localparam logic [2:0] F3_SLT  = 3'd2;
    localparam logic [2:0] F3_SLTU = 3'd3;
    localparam logic [2:0] F3_XOR  = 3'd4;
    localparam logic [2:0] F3_SR   = 3'd5;
    localparam logic [2:0] F3_OR   = 3'd6;
    localparam logic [2:0] F3_AND  = 3'd7;

    localparam logic [2:0] F3_BEQ  = 3'd0;
    localparam logic [2:0] F3_BNE  = 3'd1;
    localparam logic [2:0] F3_BLT  = 3'd4;
    localparam logic [2:0] F3_BGE  = 3'd5;
    localparam logic [2:0] F3_BLTU = 3'd6;
    localparam logic [2:0] F3_BGEU = 3'd7;

    typedef struct packed {
        logic        [PC_WIDTH-1:0]  pc;
        logic signed [XLEN-1:0]      operand_a;
        logic signed [XLEN-1:0]      operand_b;
        logic        [2:0]           instr_type;
        logic        [2:0]           func3;
        logic                        func7_bit5;
        logic signed [IMM_WIDTH-1:0] imm;
        logic                        is_jalr;
        logic                        is_load;
        logic                        is_alu_imm;
        logic                        is_lui;
    } t_exe_req;

    typedef struct packed {
        logic signed [XLEN-1:0]            result_value;
        logic        [CODE_ADDR_WIDTH-1:0] next_pc;
        logic                              redirect;
    } t_exe_rsp;

endpackage

`default_nettype wire

@@ rtl/core/rv32ex_alu.sv @@
`default_nettype none

module rv32ex_alu
    import rv32ex_pkg::*;
(
    input  wire logic [XLEN-1:0]        i_a,
    input  wire logic [XLEN-1:0]        i_b,
    input  wire logic [2:0]             i_func3,
    input  wire logic                   i_alt,
    input  wire logic                   i_r_type,
    input  wire logic [SHAMT_WIDTH-1:0] i_imm_shamt,
    output logic      [XLEN-1:0]        o_result
);

    logic [SHAMT_WIDTH-1:0] shamt;
    logic                   lt_s;
    logic                   lt_u;

    assign shamt = i_r_type ? i_b[SHAMT_WIDTH-1:0] : i_imm_shamt;
    assign lt_s  = $signed(i_a) < $signed(i_b);
    assign lt_u  = i_a < i_b;

    always_comb begin
        case (i_func3)
            F3_ADD:  o_result = (i_r_type && i_alt) ? i_a - i_b : i_a + i_b;
            F3_SLL:  o_result = i_a << shamt;
            F3_SLT:  o_result = {{(XLEN-1){1'b0}}, lt_s};
            F3_SLTU: o_result = {{(XLEN-1){1'b0}}, lt_u};
            F3_XOR:  o_result = i_a ^ i_b;
            F3_SR:   o_result = i_alt ? XLEN'($signed(i_a) >>> shamt) : i_a >> shamt;
            F3_OR:   o_result = i_a | i_b;
            F3_AND:  o_result = i_a & i_b;
            default: o_result = i_a & i_b;
        endcase
    end

endmodule

`default_nettype wire

@@ rtl/core/rv32ex_branch.sv @@
`default_nettype none

module rv32ex_branch
    import rv32ex_pkg::*;
(
    input  wire logic [XLEN-1:0] i_a,
    input  wire logic [XLEN-1:0] i_b,
    input  wire logic [2:0]      i_func3,
    output logic                 o_taken
);

    logic eq;
    logic lt_s;
    logic lt_u;

    assign eq   = i_a == i_b;
    assign lt_s = $signed(i_a) < $signed(i_b);
    assign lt_u = i_a < i_b;

    always_comb begin
        case (i_func3)
            F3_BEQ:  o_taken = eq;
            F3_BNE:  o_taken = !eq;
            F3_BLT:  o_taken = lt_s;
            F3_BGE:  o_taken = !lt_s;
            F3_BLTU: o_taken = lt_u;
            F3_BGEU: o_taken = !lt_u;
            default: o_taken = 1'b0;
        endcase
    end

endmodule

`default_nettype wire

@@ rtl/core/rv32ex_execute_unit_top_note.sv @@
`default_nettype none

module rv32ex_target
    import rv32ex_pkg::*;
(
    input  wire logic [PC_WIDTH-1:0]        i_pc,
    input  wire logic [XLEN-1:0]            i_a,
    input  wire logic [XLEN-1:0]            i_immv,
    output logic      [CODE_ADDR_WIDTH-1:0] o_pc4,
    output logic      [CODE_ADDR_WIDTH-1:0] o_jb_target,
    output logic      [CODE_ADDR_WIDTH-1:0] o_i_target,
    output logic      [XLEN-1:0]            o_mem_addr
);

    logic [XLEN-1:0] pc_ext;
    logic [XLEN-1:0] pc4_sum;
    logic [XLEN-1:0] jb_sum;

    assign pc_ext      = XLEN'(i_pc);
    assign pc4_sum     = pc_ext + XLEN'(INSTR_BYTES);
    assign jb_sum      = pc_ext + {i_immv[XLEN-2:0], 1'b0};
    assign o_mem_addr  = i_a + i_immv;
    assign o_pc4       = pc4_sum[CODE_ADDR_WIDTH-1:0];
    assign o_jb_target = jb_sum[CODE_ADDR_WIDTH-1:0];
    assign o_i_target  = {o_mem_addr[CODE_ADDR_WIDTH-1:1], 1'b0};

endmodule

`default_nettype wire

@@ rtl/core/rv32i_execute_unit.sv @@
// Execute stage of an RV32I pipeline with a decoded request in and one result out. A request
// is taken into an input register, evaluated in a single pass of combinational logic (ALU,
// address adders, branch compare) and written into a result register, and one request can be
// accepted in every cycle while the result side does not stall. A stalled result is held in
// the result register; a further request is still accepted into the input register, after
// which the input side stalls until the result is taken. Code addresses are sixteen bits wide
// and wrap; result_value is zero for branches and other types.
`default_nettype none

module rv32i_execute_unit
    import rv32ex_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_req_valid,
    output logic          o_req_stall,
    input  wire t_exe_req i_req,
    output logic          o_rsp_valid,
    input  wire logic     i_rsp_stall,
    output t_exe_rsp      o_rsp
);

    logic     r_in_valid;
    logic     n_in_valid;
    t_exe_req r_in;
    logic     r_out_valid;
    logic     n_out_valid;
    t_exe_rsp r_out;
    t_exe_rsp n_out;

    logic out_load;
    logic in_load;

    logic [XLEN-1:0]            a;
    logic [XLEN-1:0]            b;
    logic [XLEN-1:0]            immv;
    logic [XLEN-1:0]            upper;
    logic [XLEN-1:0]            alu_res;
    logic [XLEN-1:0]            mem_addr;
    logic [CODE_ADDR_WIDTH-1:0] pc4;
    logic [CODE_ADDR_WIDTH-1:0] jb_target;
    logic [CODE_ADDR_WIDTH-1:0] i_target;
    logic                       taken;

    assign out_load    = r_in_valid && (!r_out_valid || !i_rsp_stall);
    assign o_req_stall = r_in_valid && !out_load;
    assign in_load     = i_req_valid && !o_req_stall;
    assign n_in_valid  = in_load || (r_in_valid && !out_load);
    assign n_out_valid = out_load || (r_out_valid && i_rsp_stall);

    assign a     = r_in.operand_a;
    assign b     = r_in.operand_b;
    assign immv  = XLEN'(r_in.imm);
    assign upper = {r_in.imm, {UPPER_SHIFT{1'b0}}};

    rv32ex_alu u_alu (
        .i_a         (a),
        .i_b         (b),
        .i_func3     (r_in.func3),
        .i_alt       (r_in.func7_bit5),
        .i_r_type    (r_in.instr_type == TYPE_R),
        .i_imm_shamt (r_in.imm[SHAMT_WIDTH-1:0]),
        .o_result    (alu_res)
    );

    rv32ex_branch u_branch (
        .i_a     (a),
        .i_b     (b),
        .i_func3 (r_in.func3),
        .o_taken (taken)
    );

    rv32ex_target u_target (
        .i_pc        (r_in.pc),
        .i_a         (a),
        .i_immv      (immv),
        .o_pc4       (pc4),
        .o_jb_target (jb_target),
        .o_i_target  (i_target),
        .o_mem_addr  (mem_addr)
    );

    always_comb begin
        n_out.result_value = '0;
        n_out.next_pc      = pc4;
        n_out.redirect     = 1'b0;
        case (r_in.instr_type)
            TYPE_R: begin
                n_out.result_value = alu_res;
            end
            TYPE_I: begin
                if (r_in.is_jalr) begin
                    n_out.result_value = XLEN'(pc4);
                    n_out.next_pc      = i_target;
                    n_out.redirect     = 1'b1;
                end else if (r_in.is_load) begin
                    n_out.result_value = mem_addr;
                end else if (r_in.is_alu_imm) begin
                    n_out.result_value = alu_res;
                end
            end
            TYPE_S: begin
                n_out.result_value = mem_addr;
            end
            TYPE_B: begin
                if (taken) begin
                    n_out.next_pc  = jb_target;
                    n_out.redirect = 1'b1;
                end
            end
            TYPE_U: begin
                n_out.result_value = r_in.is_lui ? upper : XLEN'(r_in.pc) + upper;
            end
            TYPE_J: begin
                n_out.result_value = XLEN'(pc4);
                n_out.next_pc      = jb_target;
                n_out.redirect     = 1'b1;
            end
            default: begin
                n_out.result_value = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_load) begin
            r_in <= i_req;
        end
        if (out_load) begin
            r_out <= n_out;
        end
    end

    assign o_rsp_valid = r_out_valid;
    assign o_rsp       = r_out;

endmodule

`default_nettype wire
